### rtl/core/aes_block_cipher_ecb_assert.svh
// Assertion macros used by the top-level cipher module.
`ifndef AES_BLOCK_CIPHER_ECB_ASSERT_SVH
`define AES_BLOCK_CIPHER_ECB_ASSERT_SVH
`define AES_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/core/aes_pkg.sv
`default_nettype none
package aes_pkg;
    localparam int unsigned NumLanes = 4;
    localparam int unsigned KeyDepth = 60;
    localparam int unsigned KeyAddrW = 6;
    localparam logic [2:0] CfgKey0 = 3'd0;
    localparam logic [2:0] CfgKey1 = 3'd1;
    localparam logic [2:0] CfgKey2 = 3'd2;
    localparam logic [2:0] CfgKey3 = 3'd3;
    localparam logic [2:0] CfgKeySize = 3'd4;
    localparam logic [2:0] CfgMode = 3'd5;

    typedef logic [7:0] t_byte;

    function automatic t_byte fwd_sbox(input t_byte x);
        t_byte r;
        case (x)
8'h00:r=8'h63;8'h01:r=8'h7c;8'h02:r=8'h77;8'h03:r=8'h7b;8'h04:r=8'hf2;8'h05:r=8'h6b;8'h06:r=8'h6f;8'h07:r=8'hc5;
8'h08:r=8'h30;8'h09:r=8'h01;8'h0a:r=8'h67;8'h0b:r=8'h2b;8'h0c:r=8'hfe;8'h0d:r=8'hd7;8'h0e:r=8'hab;8'h0f:r=8'h76;
8'h10:r=8'hca;8'h11:r=8'h82;8'h12:r=8'hc9;8'h13:r=8'h7d;8'h14:r=8'hfa;8'h15:r=8'h59;8'h16:r=8'h47;8'h17:r=8'hf0;
8'h18:r=8'had;8'h19:r=8'hd4;8'h1a:r=8'ha2;8'h1b:r=8'haf;8'h1c:r=8'h9c;8'h1d:r=8'ha4;8'h1e:r=8'h72;8'h1f:r=8'hc0;
8'h20:r=8'hb7;8'h21:r=8'hfd;8'h22:r=8'h93;8'h23:r=8'h26;8'h24:r=8'h36;8'h25:r=8'h3f;8'h26:r=8'hf7;8'h27:r=8'hcc;
8'h28:r=8'h34;8'h29:r=8'ha5;8'h2a:r=8'he5;8'h2b:r=8'hf1;8'h2c:r=8'h71;8'h2d:r=8'hd8;8'h2e:r=8'h31;8'h2f:r=8'h15;
8'h30:r=8'h04;8'h31:r=8'hc7;8'h32:r=8'h23;8'h33:r=8'hc3;8'h34:r=8'h18;8'h35:r=8'h96;8'h36:r=8'h05;8'h37:r=8'h9a;
8'h38:r=8'h07;8'h39:r=8'h12;8'h3a:r=8'h80;8'h3b:r=8'he2;8'h3c:r=8'heb;8'h3d:r=8'h27;8'h3e:r=8'hb2;8'h3f:r=8'h75;
8'h40:r=8'h09;8'h41:r=8'h83;8'h42:r=8'h2c;8'h43:r=8'h1a;8'h44:r=8'h1b;8'h45:r=8'h6e;8'h46:r=8'h5a;8'h47:r=8'ha0;
8'h48:r=8'h52;8'h49:r=8'h3b;8'h4a:r=8'hd6;8'h4b:r=8'hb3;8'h4c:r=8'h29;8'h4d:r=8'he3;8'h4e:r=8'h2f;8'h4f:r=8'h84;
8'h50:r=8'h53;8'h51:r=8'hd1;8'h52:r=8'h00;8'h53:r=8'hed;8'h54:r=8'h20;8'h55:r=8'hfc;8'h56:r=8'hb1;8'h57:r=8'h5b;
8'h58:r=8'h6a;8'h59:r=8'hcb;8'h5a:r=8'hbe;8'h5b:r=8'h39;8'h5c:r=8'h4a;8'h5d:r=8'h4c;8'h5e:r=8'h58;8'h5f:r=8'hcf;
8'h60:r=8'hd0;8'h61:r=8'hef;8'h62:r=8'haa;8'h63:r=8'hfb;8'h64:r=8'h43;8'h65:r=8'h4d;8'h66:r=8'h33;8'h67:r=8'h85;
8'h68:r=8'h45;8'h69:r=8'hf9;8'h6a:r=8'h02;8'h6b:r=8'h7f;8'h6c:r=8'h50;8'h6d:r=8'h3c;8'h6e:r=8'h9f;8'h6f:r=8'ha8;
8'h70:r=8'h51;8'h71:r=8'ha3;8'h72:r=8'h40;8'h73:r=8'h8f;8'h74:r=8'h92;8'h75:r=8'h9d;8'h76:r=8'h38;8'h77:r=8'hf5;
8'h78:r=8'hbc;8'h79:r=8'hb6;8'h7a:r=8'hda;8'h7b:r=8'h21;8'h7c:r=8'h10;8'h7d:r=8'hff;8'h7e:r=8'hf3;8'h7f:r=8'hd2;
8'h80:r=8'hcd;8'h81:r=8'h0c;8'h82:r=8'h13;8'h83:r=8'hec;8'h84:r=8'h5f;8'h85:r=8'h97;8'h86:r=8'h44;8'h87:r=8'h17;
8'h88:r=8'hc4;8'h89:r=8'ha7;8'h8a:r=8'h7e;8'h8b:r=8'h3d;8'h8c:r=8'h64;8'h8d:r=8'h5d;8'h8e:r=8'h19;8'h8f:r=8'h73;
8'h90:r=8'h60;8'h91:r=8'h81;8'h92:r=8'h4f;8'h93:r=8'hdc;8'h94:r=8'h22;8'h95:r=8'h2a;8'h96:r=8'h90;8'h97:r=8'h88;
8'h98:r=8'h46;8'h99:r=8'hee;8'h9a:r=8'hb8;8'h9b:r=8'h14;8'h9c:r=8'hde;8'h9d:r=8'h5e;8'h9e:r=8'h0b;8'h9f:r=8'hdb;
8'ha0:r=8'he0;8'ha1:r=8'h32;8'ha2:r=8'h3a;8'ha3:r=8'h0a;8'ha4:r=8'h49;8'ha5:r=8'h06;8'ha6:r=8'h24;8'ha7:r=8'h5c;
8'ha8:r=8'hc2;8'ha9:r=8'hd3;8'haa:r=8'hac;8'hab:r=8'h62;8'hac:r=8'h91;8'had:r=8'h95;8'hae:r=8'he4;8'haf:r=8'h79;
8'hb0:r=8'he7;8'hb1:r=8'hc8;8'hb2:r=8'h37;8'hb3:r=8'h6d;8'hb4:r=8'h8d;8'hb5:r=8'hd5;8'hb6:r=8'h4e;8'hb7:r=8'ha9;
8'hb8:r=8'h6c;8'hb9:r=8'h56;8'hba:r=8'hf4;8'hbb:r=8'hea;8'hbc:r=8'h65;8'hbd:r=8'h7a;8'hbe:r=8'hae;8'hbf:r=8'h08;
8'hc0:r=8'hba;8'hc1:r=8'h78;8'hc2:r=8'h25;8'hc3:r=8'h2e;8'hc4:r=8'h1c;8'hc5:r=8'ha6;8'hc6:r=8'hb4;8'hc7:r=8'hc6;
8'hc8:r=8'he8;8'hc9:r=8'hdd;8'hca:r=8'h74;8'hcb:r=8'h1f;8'hcc:r=8'h4b;8'hcd:r=8'hbd;8'hce:r=8'h8b;8'hcf:r=8'h8a;
8'hd0:r=8'h70;8'hd1:r=8'h3e;8'hd2:r=8'hb5;8'hd3:r=8'h66;8'hd4:r=8'h48;8'hd5:r=8'h03;8'hd6:r=8'hf6;8'hd7:r=8'h0e;
8'hd8:r=8'h61;8'hd9:r=8'h35;8'hda:r=8'h57;8'hdb:r=8'hb9;8'hdc:r=8'h86;8'hdd:r=8'hc1;8'hde:r=8'h1d;8'hdf:r=8'h9e;
8'he0:r=8'he1;8'he1:r=8'hf8;8'he2:r=8'h98;8'he3:r=8'h11;8'he4:r=8'h69;8'he5:r=8'hd9;8'he6:r=8'h8e;8'he7:r=8'h94;
8'he8:r=8'h9b;8'he9:r=8'h1e;8'hea:r=8'h87;8'heb:r=8'he9;8'hec:r=8'hce;8'hed:r=8'h55;8'hee:r=8'h28;8'hef:r=8'hdf;
8'hf0:r=8'h8c;8'hf1:r=8'ha1;8'hf2:r=8'h89;8'hf3:r=8'h0d;8'hf4:r=8'hbf;8'hf5:r=8'he6;8'hf6:r=8'h42;8'hf7:r=8'h68;
8'hf8:r=8'h41;8'hf9:r=8'h99;8'hfa:r=8'h2d;8'hfb:r=8'h0f;8'hfc:r=8'hb0;8'hfd:r=8'h54;8'hfe:r=8'hbb;8'hff:r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_byte inv_sbox(input t_byte x);
        t_byte r;
        case (x)
8'h00:r=8'h52;8'h01:r=8'h09;8'h02:r=8'h6a;8'h03:r=8'hd5;8'h04:r=8'h30;8'h05:r=8'h36;8'h06:r=8'ha5;8'h07:r=8'h38;
8'h08:r=8'hbf;8'h09:r=8'h40;8'h0a:r=8'ha3;8'h0b:r=8'h9e;8'h0c:r=8'h81;8'h0d:r=8'hf3;8'h0e:r=8'hd7;8'h0f:r=8'hfb;
8'h10:r=8'h7c;8'h11:r=8'he3;8'h12:r=8'h39;8'h13:r=8'h82;8'h14:r=8'h9b;8'h15:r=8'h2f;8'h16:r=8'hff;8'h17:r=8'h87;
8'h18:r=8'h34;8'h19:r=8'h8e;8'h1a:r=8'h43;8'h1b:r=8'h44;8'h1c:r=8'hc4;8'h1d:r=8'hde;8'h1e:r=8'he9;8'h1f:r=8'hcb;
8'h20:r=8'h54;8'h21:r=8'h7b;8'h22:r=8'h94;8'h23:r=8'h32;8'h24:r=8'ha6;8'h25:r=8'hc2;8'h26:r=8'h23;8'h27:r=8'h3d;
8'h28:r=8'hee;8'h29:r=8'h4c;8'h2a:r=8'h95;8'h2b:r=8'h0b;8'h2c:r=8'h42;8'h2d:r=8'hfa;8'h2e:r=8'hc3;8'h2f:r=8'h4e;
8'h30:r=8'h08;8'h31:r=8'h2e;8'h32:r=8'ha1;8'h33:r=8'h66;8'h34:r=8'h28;8'h35:r=8'hd9;8'h36:r=8'h24;8'h37:r=8'hb2;
8'h38:r=8'h76;8'h39:r=8'h5b;8'h3a:r=8'ha2;8'h3b:r=8'h49;8'h3c:r=8'h6d;8'h3d:r=8'h8b;8'h3e:r=8'hd1;8'h3f:r=8'h25;
8'h40:r=8'h72;8'h41:r=8'hf8;8'h42:r=8'hf6;8'h43:r=8'h64;8'h44:r=8'h86;8'h45:r=8'h68;8'h46:r=8'h98;8'h47:r=8'h16;
8'h48:r=8'hd4;8'h49:r=8'ha4;8'h4a:r=8'h5c;8'h4b:r=8'hcc;8'h4c:r=8'h5d;8'h4d:r=8'h65;8'h4e:r=8'hb6;8'h4f:r=8'h92;
8'h50:r=8'h6c;8'h51:r=8'h70;8'h52:r=8'h48;8'h53:r=8'h50;8'h54:r=8'hfd;8'h55:r=8'hed;8'h56:r=8'hb9;8'h57:r=8'hda;
8'h58:r=8'h5e;8'h59:r=8'h15;8'h5a:r=8'h46;8'h5b:r=8'h57;8'h5c:r=8'ha7;8'h5d:r=8'h8d;8'h5e:r=8'h9d;8'h5f:r=8'h84;
8'h60:r=8'h90;8'h61:r=8'hd8;8'h62:r=8'hab;8'h63:r=8'h00;8'h64:r=8'h8c;8'h65:r=8'hbc;8'h66:r=8'hd3;8'h67:r=8'h0a;
8'h68:r=8'hf7;8'h69:r=8'he4;8'h6a:r=8'h58;8'h6b:r=8'h05;8'h6c:r=8'hb8;8'h6d:r=8'hb3;8'h6e:r=8'h45;8'h6f:r=8'h06;
8'h70:r=8'hd0;8'h71:r=8'h2c;8'h72:r=8'h1e;8'h73:r=8'h8f;8'h74:r=8'hca;8'h75:r=8'h3f;8'h76:r=8'h0f;8'h77:r=8'h02;
8'h78:r=8'hc1;8'h79:r=8'haf;8'h7a:r=8'hbd;8'h7b:r=8'h03;8'h7c:r=8'h01;8'h7d:r=8'h13;8'h7e:r=8'h8a;8'h7f:r=8'h6b;
8'h80:r=8'h3a;8'h81:r=8'h91;8'h82:r=8'h11;8'h83:r=8'h41;8'h84:r=8'h4f;8'h85:r=8'h67;8'h86:r=8'hdc;8'h87:r=8'hea;
8'h88:r=8'h97;8'h89:r=8'hf2;8'h8a:r=8'hcf;8'h8b:r=8'hce;8'h8c:r=8'hf0;8'h8d:r=8'hb4;8'h8e:r=8'he6;8'h8f:r=8'h73;
8'h90:r=8'h96;8'h91:r=8'hac;8'h92:r=8'h74;8'h93:r=8'h22;8'h94:r=8'he7;8'h95:r=8'had;8'h96:r=8'h35;8'h97:r=8'h85;
8'h98:r=8'he2;8'h99:r=8'hf9;8'h9a:r=8'h37;8'h9b:r=8'he8;8'h9c:r=8'h1c;8'h9d:r=8'h75;8'h9e:r=8'hdf;8'h9f:r=8'h6e;
8'ha0:r=8'h47;8'ha1:r=8'hf1;8'ha2:r=8'h1a;8'ha3:r=8'h71;8'ha4:r=8'h1d;8'ha5:r=8'h29;8'ha6:r=8'hc5;8'ha7:r=8'h89;
8'ha8:r=8'h6f;8'ha9:r=8'hb7;8'haa:r=8'h62;8'hab:r=8'h0e;8'hac:r=8'haa;8'had:r=8'h18;8'hae:r=8'hbe;8'haf:r=8'h1b;
8'hb0:r=8'hfc;8'hb1:r=8'h56;8'hb2:r=8'h3e;8'hb3:r=8'h4b;8'hb4:r=8'hc6;8'hb5:r=8'hd2;8'hb6:r=8'h79;8'hb7:r=8'h20;
8'hb8:r=8'h9a;8'hb9:r=8'hdb;8'hba:r=8'hc0;8'hbb:r=8'hfe;8'hbc:r=8'h78;8'hbd:r=8'hcd;8'hbe:r=8'h5a;8'hbf:r=8'hf4;
8'hc0:r=8'h1f;8'hc1:r=8'hdd;8'hc2:r=8'ha8;8'hc3:r=8'h33;8'hc4:r=8'h88;8'hc5:r=8'h07;8'hc6:r=8'hc7;8'hc7:r=8'h31;
8'hc8:r=8'hb1;8'hc9:r=8'h12;8'hca:r=8'h10;8'hcb:r=8'h59;8'hcc:r=8'h27;8'hcd:r=8'h80;8'hce:r=8'hec;8'hcf:r=8'h5f;
8'hd0:r=8'h60;8'hd1:r=8'h51;8'hd2:r=8'h7f;8'hd3:r=8'ha9;8'hd4:r=8'h19;8'hd5:r=8'hb5;8'hd6:r=8'h4a;8'hd7:r=8'h0d;
8'hd8:r=8'h2d;8'hd9:r=8'he5;8'hda:r=8'h7a;8'hdb:r=8'h9f;8'hdc:r=8'h93;8'hdd:r=8'hc9;8'hde:r=8'h9c;8'hdf:r=8'hef;
8'he0:r=8'ha0;8'he1:r=8'he0;8'he2:r=8'h3b;8'he3:r=8'h4d;8'he4:r=8'hae;8'he5:r=8'h2a;8'he6:r=8'hf5;8'he7:r=8'hb0;
8'he8:r=8'hc8;8'he9:r=8'heb;8'hea:r=8'hbb;8'heb:r=8'h3c;8'hec:r=8'h83;8'hed:r=8'h53;8'hee:r=8'h99;8'hef:r=8'h61;
8'hf0:r=8'h17;8'hf1:r=8'h2b;8'hf2:r=8'h04;8'hf3:r=8'h7e;8'hf4:r=8'hba;8'hf5:r=8'h77;8'hf6:r=8'hd6;8'hf7:r=8'h26;
8'hf8:r=8'he1;8'hf9:r=8'h69;8'hfa:r=8'h14;8'hfb:r=8'h63;8'hfc:r=8'h55;8'hfd:r=8'h21;8'hfe:r=8'h0c;8'hff:r=8'h7d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

    function automatic t_byte xtime(input t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction
endpackage
`default_nettype wire

### rtl/core/aes_keyexp.sv
`default_nettype none
module aes_keyexp
    import aes_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [255:0]        i_key,
    input  wire logic [1:0]          i_key_size,
    input  wire logic [KeyAddrW-1:0] i_rd_addr,
    output logic [31:0]              o_rd_data,
    output logic                     o_busy
);
    logic [31:0] r_mem [KeyDepth];
    logic [31:0] r_win [8];
    logic [KeyAddrW-1:0] r_idx;
    logic [KeyAddrW-1:0] r_total;
    logic [3:0] r_nk;
    logic [2:0] r_pos;
    logic [7:0] r_rcon;
    logic r_busy;
    logic [31:0] n_word;
    logic [31:0] w_t;
    logic [3:0] w_nk;

    always_comb begin
        case (i_key_size)
            2'd1: w_nk = 4'd6;
            2'd2: w_nk = 4'd8;
            default: w_nk = 4'd4;
        endcase
    end

    // r_win[0] holds word i-nk, r_win[nk-1] holds word i-1.
    always_comb begin
        w_t = r_win[r_nk[2:0] - 3'd1];
        if (r_nk == 4'd8 && r_nk[2:0] == 3'd0) w_t = r_win[7];
        if (r_pos == 3'd0) begin
            w_t = sub_word({w_t[23:0], w_t[31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_nk == 4'd8 && r_pos == 3'd4) begin
            w_t = sub_word(w_t);
        end
        n_word = r_win[0] ^ w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_idx == r_total - 6'd1) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < 8; k++) r_win[k] <= i_key[255-32*k -: 32];
            r_nk <= w_nk;
            r_idx <= 6'd0;
            r_total <= 6'(4 * (w_nk + 4'd7) > 60 ? 60 : 4 * (w_nk + 4'd7));
            r_pos <= 3'd0;
            r_rcon <= 8'h8d;
        end else if (r_busy) begin
            if (r_idx < 6'(r_nk)) begin
                r_mem[r_idx] <= r_win[r_idx[2:0]];
                if (r_idx == 6'(r_nk) - 6'd1) begin
                    r_pos <= 3'd0;
                    r_rcon <= 8'h01;
                end
            end else begin
                r_mem[r_idx] <= n_word;
                for (int k = 0; k < 7; k++)
                    if (k < r_nk - 1) r_win[k] <= r_win[k+1];
                r_win[r_nk[2:0] - 3'd1] <= n_word;
                if (r_pos == 3'(r_nk - 4'd1)) begin
                    r_pos <= 3'd0;
                    r_rcon <= xtime(r_rcon);
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
            r_idx <= r_idx + 6'd1;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_busy = r_busy;
endmodule
`default_nettype wire

### rtl/core/aes_lane.sv
`default_nettype none
module aes_lane
    import aes_pkg::*;
(
    input  wire logic [127:0] i_state,
    input  wire logic [1:0]   i_col,
    input  wire logic         i_enc,
    input  wire logic         i_mix,
    input  wire logic [31:0]  i_rk,
    output logic [31:0]       o_col
);
    t_byte w_s [4];
    t_byte w_m [4];
    t_byte w_a [4];
    t_byte w_x2 [4];
    t_byte w_x4 [4];
    t_byte w_x8 [4];
    logic [1:0] w_src [4];

    // Column of the shifted, substituted state; byte 4*c+r at bits 127-8*(4c+r).
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_src[r] = i_enc ? i_col + 2'(r) : i_col - 2'(r);
            w_s[r] = i_state[127 - 8*(4*int'(w_src[r]) + r) -: 8];
            w_s[r] = i_enc ? fwd_sbox(w_s[r]) : inv_sbox(w_s[r]);
        end
        for (int r = 0; r < 4; r++) begin
            w_a[r] = i_enc ? w_s[r] : w_s[r] ^ i_rk[31-8*r -: 8];
            w_x2[r] = xtime(w_a[r]);
            w_x4[r] = xtime(w_x2[r]);
            w_x8[r] = xtime(w_x4[r]);
        end
        for (int r = 0; r < 4; r++) begin
            if (i_enc) begin
                w_m[r] = w_x2[r] ^ w_x2[(r+1)%4] ^ w_a[(r+1)%4] ^ w_a[(r+2)%4] ^ w_a[(r+3)%4];
            end else begin
                w_m[r] = (w_x8[r] ^ w_x4[r] ^ w_x2[r])
                       ^ (w_x8[(r+1)%4] ^ w_x2[(r+1)%4] ^ w_a[(r+1)%4])
                       ^ (w_x8[(r+2)%4] ^ w_x4[(r+2)%4] ^ w_a[(r+2)%4])
                       ^ (w_x8[(r+3)%4] ^ w_a[(r+3)%4]);
            end
            if (!i_mix) w_m[r] = w_a[r];
            if (i_enc) w_m[r] = w_m[r] ^ i_rk[31-8*r -: 8];
        end
        o_col = {w_m[0], w_m[1], w_m[2], w_m[3]};
    end
endmodule
`default_nettype wire

### rtl/core/aes_block_cipher_ecb.sv
// AES-128/192/256 ECB block cipher.
// Configuration: i_cfg_we writes register i_cfg_index (0-3 key parts, 4 key
// size, 5 direction) with i_cfg_data. A key or key-size write starts the key
// expansion, one round-key word per cycle.
// Input channel i_valid/o_stall carries one 128-bit block per beat; output
// channel o_valid/i_stall returns the result block.
// Each block takes an initial round-key step and one step per round
// (10, 12 or 14 rounds): the four words of a round key are read from the
// 60-word key memory one per cycle, then four column lanes compute the
// step in parallel and merge into the state register. The result is then
// moved to the output register; a new block is taken only once the previous
// result has moved there, the single key-memory read port serialising the
// round-key fetches.
// After reset the all-zero 128-bit key is expanded before the first block
// is taken; o_stall is high meanwhile. While the receiver stalls, the result
// stays in the output register and the next block may be taken.
`default_nettype none
module aes_block_cipher_ecb
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_block_word_0,
    input  wire logic [31:0] i_block_word_1,
    input  wire logic [31:0] i_block_word_2,
    input  wire logic [31:0] i_block_word_3,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_out_word_0,
    output logic [31:0]      o_out_word_1,
    output logic [31:0]      o_out_word_2,
    output logic [31:0]      o_out_word_3
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StFetch = 3'd1;
    localparam logic [2:0] StRound = 3'd2;
    localparam logic [2:0] StDone = 3'd3;
    localparam logic [2:0] StInit = 3'd4;

    logic [255:0] r_key;
    logic [1:0] r_ksize;
    logic r_enc;
    logic r_start;
    logic [2:0] r_st;
    logic [127:0] r_state;
    logic [127:0] r_rk;
    logic [3:0] r_round;
    logic [3:0] r_nr;
    logic [2:0] r_fcnt;
    logic r_first;
    logic r_ovalid;
    logic [127:0] r_out;
    logic [KeyAddrW-1:0] w_addr;
    logic [31:0] w_rd;
    logic w_kbusy;
    logic [127:0] w_next;
    logic w_last;
    logic w_in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_ksize <= 2'd0;
            r_enc <= 1'b1;
            r_start <= 1'b1;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgKey0: begin r_key[255:192] <= i_cfg_data; r_start <= 1'b1; end
                    CfgKey1: begin r_key[191:128] <= i_cfg_data; r_start <= 1'b1; end
                    CfgKey2: begin r_key[127:64] <= i_cfg_data; r_start <= 1'b1; end
                    CfgKey3: begin r_key[63:0] <= i_cfg_data; r_start <= 1'b1; end
                    CfgKeySize: begin r_ksize <= i_cfg_data[1:0]; r_start <= 1'b1; end
                    CfgMode: r_enc <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    aes_keyexp u_keyexp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_key(r_key),
        .i_key_size(r_ksize), .i_rd_addr(w_addr), .o_rd_data(w_rd), .o_busy(w_kbusy)
    );

    // Address of the word fetched now; the key-memory read is registered, so its data arrives in the next cycle.
    assign w_addr = 6'({r_round, 2'b00}) + 6'(r_fcnt[1:0]);
    assign w_last = r_enc ? (r_round == r_nr) : (r_round == 4'd0);

    generate
        for (genvar g = 0; g < NumLanes; g++) begin : g_lane
            aes_lane u_lane (
                .i_state(r_state), .i_col(2'(g)), .i_enc(r_enc), .i_mix(!w_last),
                .i_rk(r_rk[127-32*g -: 32]), .o_col(w_next[127-32*g -: 32])
            );
        end
    endgenerate

    assign w_in_acc = i_valid && !o_stall;
    assign o_stall = (r_st != StIdle) || r_start || w_kbusy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == StDone && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                StIdle: if (w_in_acc) r_st <= StFetch;
                StFetch: if (r_fcnt == 3'd4) r_st <= r_first ? StInit : StRound;
                StInit: r_st <= StFetch;
                StRound: r_st <= w_last ? StDone : StFetch;
                StDone: if (!r_ovalid || !i_stall) r_st <= StIdle;
                default: r_st <= StIdle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            StIdle: if (w_in_acc) begin
                r_state <= {i_block_word_0, i_block_word_1, i_block_word_2, i_block_word_3};
                r_nr <= (r_ksize == 2'd1) ? 4'd12 : (r_ksize == 2'd2) ? 4'd14 : 4'd10;
                r_round <= r_enc ? 4'd0
                         : ((r_ksize == 2'd1) ? 4'd12 : (r_ksize == 2'd2) ? 4'd14 : 4'd10);
                r_fcnt <= 3'd0;
                r_first <= 1'b1;
            end
            StFetch: begin
                r_fcnt <= r_fcnt + 3'd1;
                if (r_fcnt != 3'd0) r_rk <= {r_rk[95:0], w_rd};
            end
            StInit: begin
                r_state <= r_state ^ r_rk;
                r_first <= 1'b0;
                r_round <= r_enc ? r_round + 4'd1 : r_round - 4'd1;
                r_fcnt <= 3'd0;
            end
            StRound: begin
                r_state <= w_next;
                if (!w_last) r_round <= r_enc ? r_round + 4'd1 : r_round - 4'd1;
                r_fcnt <= 3'd0;
            end
            StDone: if (!r_ovalid || !i_stall) r_out <= r_state;
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_out_word_0 = r_out[127:96];
    assign o_out_word_1 = r_out[95:64];
    assign o_out_word_2 = r_out[63:32];
    assign o_out_word_3 = r_out[31:0];

`include "aes_block_cipher_ecb_assert.svh"
    `AES_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, w_kbusy, o_stall)
    `AES_ASSERT_NEXT(a_round_bound, i_clk, i_rst_n, r_st == StRound, r_round <= 4'd14)
    `AES_ASSERT_IMPL(a_idle_on_start, i_clk, i_rst_n, r_start, r_st == StIdle || r_first)
endmodule
`default_nettype wire
